// File: design/point_cloud_range_gate_transform_macros.svh
// Assertion helpers shared by prc_queue, prc_back and the top-level design file.
`ifndef POINT_CLOUD_RANGE_GATE_TRANSFORM_MACROS_SVH
`define POINT_CLOUD_RANGE_GATE_TRANSFORM_MACROS_SVH

`ifndef SYNTHESIS
`define PRC_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: property failed");
`define PRC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: property failed");
`else
`define PRC_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define PRC_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// File: design/prc_pkg.sv
package prc_pkg;

    localparam int COUNT_WIDTH_DEF     = 20;
    localparam int COORD_FRAC_BITS_DEF = 12;

    localparam int COORD_W       = 24;
    localparam int COEF_W        = 18;
    localparam int VAR_W         = 32;
    localparam int CFG_W         = 54;
    localparam int CFG_ADDR_W    = 3;
    localparam int POINT_LIMIT_W = 20;
    localparam int PROD_W        = COEF_W + COORD_W;
    localparam int SUM_W         = PROD_W + 2;
    localparam int ROUND_BITS    = 16;
    localparam int OUT_PRE_W     = SUM_W - ROUND_BITS + 1;
    localparam int RSQ_W         = 2 * COORD_W;
    localparam int QUEUE_DEPTH   = 8;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_W-1:0]         ROT_ROW0_RST    = 54'd65536;
    localparam logic [CFG_W-1:0]         ROT_ROW1_RST    = 54'd17179869184;
    localparam logic [CFG_W-1:0]         ROT_ROW2_RST    = 54'd4503599627370496;
    localparam logic [2*COORD_W-1:0]     RANGE_RST       = 48'd618475290993;
    localparam logic [VAR_W-1:0]         DEF_VAR_RST     = 32'd10486;
    localparam logic [POINT_LIMIT_W-1:0] POINT_LIMIT_RST = 20'd60000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ROT_ROW0,
        REG_ROT_ROW1,
        REG_ROT_ROW2,
        REG_TRANS_XY,
        REG_TRANS_Z,
        REG_RANGE_LIMITS,
        REG_DEF_VAR,
        REG_POINT_LIMIT
    } prc_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_in;
        logic signed [COORD_W-1:0] y_in;
        logic signed [COORD_W-1:0] z_in;
        logic                      coords_valid;
        logic [VAR_W-1:0]          variance_in;
        logic                      variance_present;
        logic                      frame_last;
    } prc_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_out;
        logic signed [COORD_W-1:0] y_out;
        logic signed [COORD_W-1:0] z_out;
        logic [VAR_W-1:0]          variance_out;
        logic                      point_present;
        logic                      frame_end;
    } prc_out_t;

    typedef struct packed {
        logic [CFG_W-1:0]          rot_row0;
        logic [CFG_W-1:0]          rot_row1;
        logic [CFG_W-1:0]          rot_row2;
        logic signed [COORD_W-1:0] trans_x;
        logic signed [COORD_W-1:0] trans_y;
        logic signed [COORD_W-1:0] trans_z;
        logic [COORD_W-1:0]        range_min;
        logic [COORD_W-1:0]        range_max;
    } prc_xform_cfg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [VAR_W-1:0]          variance;
        logic                      variance_ok;
        logic                      keep;
        logic                      last;
    } prc_entry_t;

endpackage

// File: design/prc_front.sv
module prc_front #(
    parameter int COORD_FRAC_BITS = prc_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    input  prc_pkg::prc_in_t       in_data,
    input  prc_pkg::prc_xform_cfg_t cfg,
    output logic                   push,
    output prc_pkg::prc_entry_t    push_data,
    output logic [1:0]             inflight
);

    typedef struct packed {
        logic [prc_pkg::VAR_W-1:0] variance;
        logic                      variance_ok;
        logic                      coords_valid;
        logic                      last;
    } prc_tag_t;

    logic signed [prc_pkg::COORD_W-1:0]   crd [3];
    logic [prc_pkg::CFG_W-1:0]            rows [3];
    logic signed [prc_pkg::COORD_W-1:0]   trans [3];
    logic signed [prc_pkg::COEF_W-1:0]    coef_c [3][3];
    logic signed [prc_pkg::PROD_W-1:0]    prod_c [3][3];
    logic signed [prc_pkg::RSQ_W-1:0]     sq_c [3];
    logic signed [prc_pkg::SUM_W-1:0]     rnd_c [3];
    logic signed [prc_pkg::OUT_PRE_W-1:0] o_c [3];
    logic [prc_pkg::RSQ_W-1:0]            lo_ext;
    logic [prc_pkg::RSQ_W-1:0]            hi_ext;
    logic                                 range_ok_c;
    logic [2:0]                           fits;

    logic                                 s1_valid_reg, s2_valid_reg, s3_valid_reg;
    prc_tag_t                             s1_tag_reg, s2_tag_reg, s3_tag_reg;
    logic signed [prc_pkg::PROD_W-1:0]    prod_reg [3][3];
    logic [prc_pkg::RSQ_W-1:0]            sq_reg [3];
    logic signed [prc_pkg::SUM_W-1:0]     sum_reg [3];
    logic [prc_pkg::RSQ_W-1:0]            rsq_reg;
    logic signed [prc_pkg::OUT_PRE_W-1:0] o_reg [3];
    logic                                 range_ok_reg;

    always_comb begin
        crd[0]   = in_data.x_in;
        crd[1]   = in_data.y_in;
        crd[2]   = in_data.z_in;
        rows[0]  = cfg.rot_row0;
        rows[1]  = cfg.rot_row1;
        rows[2]  = cfg.rot_row2;
        trans[0] = cfg.trans_x;
        trans[1] = cfg.trans_y;
        trans[2] = cfg.trans_z;
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                coef_c[r][k] = $signed(rows[r][prc_pkg::COEF_W*k +: prc_pkg::COEF_W]);
                prod_c[r][k] = coef_c[r][k] * crd[k];
            end
            sq_c[r] = crd[r] * crd[r];
        end
    end

    // stage 1: products and squares
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
        end
        s1_tag_reg.variance     <= in_data.variance_in;
        s1_tag_reg.variance_ok  <= in_data.variance_present && (in_data.variance_in != '0);
        s1_tag_reg.coords_valid <= in_data.coords_valid;
        s1_tag_reg.last         <= in_data.frame_last;
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                prod_reg[r][k] <= prod_c[r][k];
            end
            sq_reg[r] <= sq_c[r];
        end
    end

    // stage 2: row sums and squared range
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg;
        end
        s2_tag_reg <= s1_tag_reg;
        for (int r = 0; r < 3; r++) begin
            sum_reg[r] <= prod_reg[r][0] + prod_reg[r][1] + prod_reg[r][2];
        end
        rsq_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
    end

    always_comb begin
        lo_ext = prc_pkg::RSQ_W'({cfg.range_min, {COORD_FRAC_BITS{1'b0}}});
        hi_ext = prc_pkg::RSQ_W'({cfg.range_max, {COORD_FRAC_BITS{1'b0}}});
        range_ok_c = !((rsq_reg < lo_ext) || (rsq_reg > hi_ext));
        for (int r = 0; r < 3; r++) begin
            rnd_c[r] = sum_reg[r] + prc_pkg::SUM_W'(1 << (prc_pkg::ROUND_BITS - 1));
            o_c[r]   = $signed(rnd_c[r][prc_pkg::SUM_W-1:prc_pkg::ROUND_BITS]) + trans[r];
        end
    end

    // stage 3: round, translate, range window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else begin
            s3_valid_reg <= s2_valid_reg;
        end
        s3_tag_reg   <= s2_tag_reg;
        range_ok_reg <= s2_tag_reg.coords_valid && range_ok_c;
        for (int r = 0; r < 3; r++) begin
            o_reg[r] <= o_c[r];
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            fits[r] = (&o_reg[r][prc_pkg::OUT_PRE_W-1:prc_pkg::COORD_W-1])
                   || !(|o_reg[r][prc_pkg::OUT_PRE_W-1:prc_pkg::COORD_W-1]);
        end
        push_data.x           = o_reg[0][prc_pkg::COORD_W-1:0];
        push_data.y           = o_reg[1][prc_pkg::COORD_W-1:0];
        push_data.z           = o_reg[2][prc_pkg::COORD_W-1:0];
        push_data.variance    = s3_tag_reg.variance;
        push_data.variance_ok = s3_tag_reg.variance_ok;
        push_data.keep        = range_ok_reg && (&fits);
        push_data.last        = s3_tag_reg.last;
        push     = s3_valid_reg && (push_data.keep || push_data.last);
        inflight = {1'b0, s1_valid_reg} + {1'b0, s2_valid_reg} + {1'b0, s3_valid_reg};
    end

endmodule

// File: design/prc_queue.sv
`include "point_cloud_range_gate_transform_macros.svh"

module prc_queue (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                push,
    input  prc_pkg::prc_entry_t                 push_data,
    input  logic                                pop,
    output logic                                head_valid,
    output prc_pkg::prc_entry_t                 head,
    output logic [prc_pkg::QUEUE_PTR_W:0]       count
);

    prc_pkg::prc_entry_t                  mem [prc_pkg::QUEUE_DEPTH];
    logic [prc_pkg::QUEUE_PTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [prc_pkg::QUEUE_PTR_W:0]        count_reg, count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign count      = count_reg;

    `PRC_ASSERT_IMPLIES(a_count_bound, aclk, aresetn, 1'b1, count_reg <= prc_pkg::QUEUE_DEPTH)
    `PRC_ASSERT_IMPLIES(a_pop_nonempty, aclk, aresetn, pop, count_reg != '0)

endmodule

// File: design/prc_back.sv
`include "point_cloud_range_gate_transform_macros.svh"

module prc_back #(
    parameter int COUNT_WIDTH = prc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               head_valid,
    input  prc_pkg::prc_entry_t                head,
    input  logic [prc_pkg::VAR_W-1:0]          dflt_var,
    input  logic [prc_pkg::POINT_LIMIT_W-1:0]  point_limit,
    output logic                               pop,
    output logic                               m_valid,
    output prc_pkg::prc_out_t                  m_data,
    input  logic                               m_ready
);

    localparam int CMP_W = (COUNT_WIDTH > prc_pkg::POINT_LIMIT_W) ? COUNT_WIDTH
                                                                  : prc_pkg::POINT_LIMIT_W;

    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   m_valid_reg, m_valid_next;
    prc_pkg::prc_out_t      m_data_reg, m_data_next;
    logic                   keep;
    logic                   emit;

    always_comb begin
        pop  = head_valid && (!m_valid_reg || m_ready);
        keep = head.keep && (CMP_W'(count_reg) < CMP_W'(point_limit)) && !(&count_reg);
        emit = pop && (keep || head.last);

        count_next = count_reg;
        if (pop) begin
            if (head.last) begin
                count_next = '0;
            end else if (keep) begin
                count_next = count_reg + 1'b1;
            end
        end

        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        m_data_next               = m_data_reg;
        if (emit) begin
            m_data_next.x_out         = keep ? head.x : '0;
            m_data_next.y_out         = keep ? head.y : '0;
            m_data_next.z_out         = keep ? head.z : '0;
            m_data_next.variance_out  = !keep ? '0
                                      : (head.variance_ok ? head.variance : dflt_var);
            m_data_next.point_present = keep;
            m_data_next.frame_end     = head.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `PRC_ASSERT_NEXT(a_frame_clears, aclk, aresetn, pop && head.last, count_reg == '0)
    `PRC_ASSERT_NEXT(a_kept_counts, aclk, aresetn, pop && !head.last && keep,
        count_reg == COUNT_WIDTH'($past(count_reg) + 1'b1))

endmodule

// File: design/point_cloud_range_gate_transform.sv
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_data  (prc_in_t)
// m_        out        m_valid / m_ready   m_data  (prc_out_t)
// cfg_      in         cfg_wr_en           cfg_addr, cfg_wr_data
//
// One point per cycle sustained while s_ready stays high; m_valid rises once the point has
// passed the first arithmetic stage, two more stages, the queue and the output register.
// s_ready drops when the points in the arithmetic stages plus the queue fill reach
// the queue depth of eight, so m_ready stalls back up into s_ready after that.
// aresetn is synchronous; reset loads the default transform and clears the frame count.

`include "point_cloud_range_gate_transform_macros.svh"

module point_cloud_range_gate_transform #(
    parameter int COUNT_WIDTH     = prc_pkg::COUNT_WIDTH_DEF,
    parameter int COORD_FRAC_BITS = prc_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  prc_pkg::prc_in_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output prc_pkg::prc_out_t                m_data,
    input  logic                             cfg_wr_en,
    input  logic [prc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [prc_pkg::CFG_W-1:0]        cfg_wr_data
);

    prc_pkg::prc_xform_cfg_t              xcfg_reg;
    logic [prc_pkg::VAR_W-1:0]            def_var_reg;
    logic [prc_pkg::POINT_LIMIT_W-1:0]    point_limit_reg;

    logic                                 push, pop, head_valid;
    prc_pkg::prc_entry_t                  push_data, head;
    logic [1:0]                           inflight;
    logic [prc_pkg::QUEUE_PTR_W:0]        q_count;
    logic [prc_pkg::QUEUE_PTR_W+1:0]      credit_used;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xcfg_reg.rot_row0  <= prc_pkg::ROT_ROW0_RST;
            xcfg_reg.rot_row1  <= prc_pkg::ROT_ROW1_RST;
            xcfg_reg.rot_row2  <= prc_pkg::ROT_ROW2_RST;
            xcfg_reg.trans_x   <= '0;
            xcfg_reg.trans_y   <= '0;
            xcfg_reg.trans_z   <= '0;
            xcfg_reg.range_min <= prc_pkg::RANGE_RST[prc_pkg::COORD_W-1:0];
            xcfg_reg.range_max <= prc_pkg::RANGE_RST[2*prc_pkg::COORD_W-1:prc_pkg::COORD_W];
            def_var_reg        <= prc_pkg::DEF_VAR_RST;
            point_limit_reg    <= prc_pkg::POINT_LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (prc_pkg::prc_reg_t'(cfg_addr))
                prc_pkg::REG_ROT_ROW0: begin
                    xcfg_reg.rot_row0 <= cfg_wr_data;
                end
                prc_pkg::REG_ROT_ROW1: begin
                    xcfg_reg.rot_row1 <= cfg_wr_data;
                end
                prc_pkg::REG_ROT_ROW2: begin
                    xcfg_reg.rot_row2 <= cfg_wr_data;
                end
                prc_pkg::REG_TRANS_XY: begin
                    xcfg_reg.trans_x <= cfg_wr_data[prc_pkg::COORD_W-1:0];
                    xcfg_reg.trans_y <= cfg_wr_data[2*prc_pkg::COORD_W-1:prc_pkg::COORD_W];
                end
                prc_pkg::REG_TRANS_Z: begin
                    xcfg_reg.trans_z <= cfg_wr_data[prc_pkg::COORD_W-1:0];
                end
                prc_pkg::REG_RANGE_LIMITS: begin
                    xcfg_reg.range_min <= cfg_wr_data[prc_pkg::COORD_W-1:0];
                    xcfg_reg.range_max <= cfg_wr_data[2*prc_pkg::COORD_W-1:prc_pkg::COORD_W];
                end
                prc_pkg::REG_DEF_VAR: begin
                    def_var_reg <= cfg_wr_data[prc_pkg::VAR_W-1:0];
                end
                prc_pkg::REG_POINT_LIMIT: begin
                    point_limit_reg <= cfg_wr_data[prc_pkg::POINT_LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // every point in flight owns a queue slot before it is accepted
    assign credit_used = {1'b0, q_count} + (prc_pkg::QUEUE_PTR_W+2)'(inflight);
    assign s_ready     = credit_used < (prc_pkg::QUEUE_PTR_W+2)'(prc_pkg::QUEUE_DEPTH);

    prc_front #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid && s_ready),
        .in_data   (s_data),
        .cfg       (xcfg_reg),
        .push      (push),
        .push_data (push_data),
        .inflight  (inflight)
    );

    prc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .count      (q_count)
    );

    prc_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (head_valid),
        .head        (head),
        .dflt_var    (def_var_reg),
        .point_limit (point_limit_reg),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_data      (m_data),
        .m_ready     (m_ready)
    );

    `PRC_ASSERT_IMPLIES(a_credit_bound, aclk, aresetn, 1'b1,
        credit_used <= (prc_pkg::QUEUE_PTR_W+2)'(prc_pkg::QUEUE_DEPTH))

endmodule

// File: tb/sv/point_cloud_range_gate_transform_tb.sv
`timescale 1ns / 100ps

module point_cloud_range_gate_transform_tb;
    import prc_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 200;
    localparam logic [COUNT_WIDTH_DEF-1:0] COUNT_MAX = '1;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    prc_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    prc_out_t              m_data;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wr_data;

    // Shadow of the register file and of the per-frame point count.
    logic [CFG_W-1:0]           rot_row0_cfg;
    logic [CFG_W-1:0]           rot_row1_cfg;
    logic [CFG_W-1:0]           rot_row2_cfg;
    logic [2*COORD_W-1:0]       trans_xy_cfg;
    logic [COORD_W-1:0]         trans_z_cfg;
    logic [2*COORD_W-1:0]       range_cfg;
    logic [VAR_W-1:0]           def_var_cfg;
    logic [POINT_LIMIT_W-1:0]   point_limit_cfg;
    logic [COUNT_WIDTH_DEF-1:0] frame_points = '0;

    prc_out_t expected_points[$];
    int       mismatch_count = 0;
    int       cycle_count = 0;
    int       tx_idle_pct = 0;
    int       rx_stall_pct = 0;
    int       hold_req = 0;
    int       hold_seen = 0;
    int       hold_left = 0;

    point_cloud_range_gate_transform DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic longint rotate_row(logic [CFG_W-1:0] row, longint x, longint y,
                                          longint z, longint t);
        longint c0, c1, c2, acc;
        c0 = longint'(signed'(row[17:0]));
        c1 = longint'(signed'(row[35:18]));
        c2 = longint'(signed'(row[53:36]));
        acc = c0 * x + c1 * y + c2 * z;
        // round to nearest, ties toward plus infinity
        return ((acc + 32768) >>> 16) + t;
    endfunction

    function automatic bit transform_point(input prc_in_t p, output prc_out_t r);
        longint px, py, pz, rsq, lo, hi, ox, oy, oz;
        bit keep;
        px = longint'(signed'(p.x_in));
        py = longint'(signed'(p.y_in));
        pz = longint'(signed'(p.z_in));
        keep = p.coords_valid;
        rsq = px * px + py * py + pz * pz;
        lo = longint'(range_cfg[23:0]) << COORD_FRAC_BITS_DEF;
        hi = longint'(range_cfg[47:24]) << COORD_FRAC_BITS_DEF;
        if (rsq < lo || rsq > hi) begin
            keep = 1'b0;
        end
        ox = rotate_row(rot_row0_cfg, px, py, pz, longint'(signed'(trans_xy_cfg[23:0])));
        oy = rotate_row(rot_row1_cfg, px, py, pz, longint'(signed'(trans_xy_cfg[47:24])));
        oz = rotate_row(rot_row2_cfg, px, py, pz, longint'(signed'(trans_z_cfg)));
        if (ox < -8388608 || ox > 8388607 || oy < -8388608 || oy > 8388607 ||
            oz < -8388608 || oz > 8388607) begin
            keep = 1'b0;
        end
        if (frame_points >= point_limit_cfg || frame_points >= COUNT_MAX) begin
            keep = 1'b0;
        end
        r = '0;
        if (keep) begin
            r.x_out = ox[23:0];
            r.y_out = oy[23:0];
            r.z_out = oz[23:0];
            r.variance_out = (p.variance_present && p.variance_in != 0) ?
                             p.variance_in : def_var_cfg;
            r.point_present = 1'b1;
            frame_points = frame_points + 1'b1;
        end
        if (p.frame_last) begin
            frame_points = '0;
        end
        r.frame_end = p.frame_last;
        return keep || p.frame_last;
    endfunction

    task automatic log_mismatch(string tag, prc_out_t want, prc_out_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t %s: expected x=%0d y=%0d z=%0d var=%0d pt=%0b end=%0b", $time, tag,
                     want.x_out, want.y_out, want.z_out, want.variance_out,
                     want.point_present, want.frame_end);
            $display("%0t %s: actual   x=%0d y=%0d z=%0d var=%0d pt=%0b end=%0b", $time, tag,
                     got.x_out, got.y_out, got.z_out, got.variance_out,
                     got.point_present, got.frame_end);
        end
    endtask

    always @(posedge aclk) begin : check_results
        prc_out_t want;
        prc_out_t got;
        prc_out_t next_result;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = m_data;
                if (expected_points.size() == 0) begin
                    log_mismatch("unexpected transaction", '0, got);
                end else begin
                    want = expected_points.pop_front();
                    if (got.x_out !== want.x_out || got.y_out !== want.y_out ||
                        got.z_out !== want.z_out || got.variance_out !== want.variance_out ||
                        got.point_present !== want.point_present ||
                        got.frame_end !== want.frame_end) begin
                        log_mismatch("mismatch", want, got);
                    end
                end
            end
            if (s_valid && s_ready && transform_point(s_data, next_result)) begin
                expected_points.insert(expected_points.size(), next_result);
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_point(prc_in_t p);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (10) @(posedge aclk);
        while (expected_points.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(prc_reg_t idx, logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        case (idx)
            REG_ROT_ROW0:     rot_row0_cfg = value;
            REG_ROT_ROW1:     rot_row1_cfg = value;
            REG_ROT_ROW2:     rot_row2_cfg = value;
            REG_TRANS_XY:     trans_xy_cfg = value[47:0];
            REG_TRANS_Z:      trans_z_cfg = value[23:0];
            REG_RANGE_LIMITS: range_cfg = value[47:0];
            REG_DEF_VAR:      def_var_cfg = value[31:0];
            REG_POINT_LIMIT:  point_limit_cfg = value[19:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic prc_in_t make_point(int x, int y, int z, bit valid, logic [31:0] var_val,
                                           bit var_ok, bit last);
        prc_in_t p;
        p.x_in = 24'(x);
        p.y_in = 24'(y);
        p.z_in = 24'(z);
        p.coords_valid = valid;
        p.variance_in = var_val;
        p.variance_present = var_ok;
        p.frame_last = last;
        return p;
    endfunction

    function automatic logic [COORD_W-1:0] random_coord();
        int sel;
        sel = $urandom_range(99);
        if (sel < 55) return 24'($urandom_range(16384) - 8192);
        if (sel < 75) return 24'($urandom_range(131072) - 65536);
        if (sel < 90) return 24'($urandom_range(524288) - 262144);
        return 24'($urandom);
    endfunction

    function automatic prc_in_t random_point();
        prc_in_t p;
        p.x_in = random_coord();
        p.y_in = random_coord();
        p.z_in = random_coord();
        p.coords_valid = ($urandom_range(99) < 90);
        p.variance_in = ($urandom_range(4) == 0) ? 32'd0 : 32'($urandom);
        p.variance_present = 1'($urandom_range(1));
        p.frame_last = ($urandom_range(11) == 0);
        return p;
    endfunction

    function automatic logic [COEF_W-1:0] small_coef();
        return 18'($urandom_range(131072) - 65536);
    endfunction

    function automatic logic [COEF_W-1:0] extreme_coef();
        case ($urandom_range(2))
            0:       return 18'h1FFFF;
            1:       return 18'h20000;
            default: return 18'h00000;
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] extreme_offset();
        case ($urandom_range(2))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            default: return 24'h000000;
        endcase
    endfunction

    task automatic configure_setup(int kind);
        logic [CFG_W-1:0]         r0, r1, r2;
        logic [2*COORD_W-1:0]     txy, rng;
        logic [COORD_W-1:0]       tz;
        logic [VAR_W-1:0]         dv;
        logic [POINT_LIMIT_W-1:0] mp;
        r0  = ROT_ROW0_RST;
        r1  = ROT_ROW1_RST;
        r2  = ROT_ROW2_RST;
        txy = '0;
        tz  = '0;
        rng = RANGE_RST;
        dv  = DEF_VAR_RST;
        mp  = POINT_LIMIT_RST;
        case (kind)
            1: begin
                r0  = {small_coef(), small_coef(), small_coef()};
                r1  = {small_coef(), small_coef(), small_coef()};
                r2  = {small_coef(), small_coef(), small_coef()};
                txy = {24'($urandom_range(131072) - 65536), 24'($urandom_range(131072) - 65536)};
                tz  = 24'($urandom_range(131072) - 65536);
                rng = {24'($urandom_range(24'hFFFFFF, 16384)), 24'($urandom_range(4096))};
                dv  = ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom);
                mp  = 20'($urandom_range(6, 1));
            end
            2: begin
                r0  = {extreme_coef(), extreme_coef(), extreme_coef()};
                r1  = {extreme_coef(), extreme_coef(), extreme_coef()};
                r2  = {extreme_coef(), extreme_coef(), extreme_coef()};
                txy = {extreme_offset(), extreme_offset()};
                tz  = extreme_offset();
                rng = {24'hFFFFFF, 24'h000000};
                dv  = $urandom_range(1) ? 32'hFFFFFFFF : 32'd0;
                mp  = 20'hFFFFF;
            end
            3: begin
                // no point may pass, only frame ends come out
                mp = '0;
                dv = '0;
            end
            4: begin
                r0  = CFG_W'({$urandom, $urandom});
                r1  = CFG_W'({$urandom, $urandom});
                r2  = CFG_W'({$urandom, $urandom});
                txy = 48'({$urandom, $urandom});
                tz  = 24'($urandom);
                rng = 48'({$urandom, $urandom});
                dv  = $urandom;
                mp  = 20'($urandom);
            end
            default: ;
        endcase
        write_reg(REG_ROT_ROW0, r0);
        write_reg(REG_ROT_ROW1, r1);
        write_reg(REG_ROT_ROW2, r2);
        write_reg(REG_TRANS_XY, txy);
        write_reg(REG_TRANS_Z, tz);
        write_reg(REG_RANGE_LIMITS, rng);
        write_reg(REG_DEF_VAR, dv);
        write_reg(REG_POINT_LIMIT, mp);
    endtask

    task automatic test_directed_cases();
        // reset transform, window 0.3 m to 3 m
        send_point(make_point(4096, 0, 0, 1, 32'd0, 0, 0));
        send_point(make_point(0, 4096, 2048, 1, 32'h12345678, 1, 0));
        send_point(make_point(2048, 2048, 0, 1, 32'd0, 1, 0));
        send_point(make_point(4096, 0, 0, 1, 32'hFFFFFFFF, 0, 0));
        send_point(make_point(4096, 0, 0, 0, 32'd77, 1, 0));
        send_point(make_point(0, 0, 0, 1, 32'd5, 1, 0));
        send_point(make_point(-8388608, 8388607, -8388608, 1, 32'hFFFFFFFF, 1, 0));
        send_point(make_point(8388607, -8388608, 8388607, 1, 32'd0, 0, 1));
        wait_idle();
        // window edges are inclusive
        write_reg(REG_RANGE_LIMITS, {24'd16384, 24'd4096});
        send_point(make_point(4096, 0, 0, 1, 32'd1, 1, 0));
        send_point(make_point(0, 4095, 0, 1, 32'd1, 1, 0));
        send_point(make_point(0, 0, 8192, 1, 32'd1, 1, 0));
        send_point(make_point(8193, 0, 0, 1, 32'd1, 1, 1));
        wait_idle();
        // half-scale x coefficient exposes rounding ties
        write_reg(REG_RANGE_LIMITS, {24'hFFFFFF, 24'h000000});
        write_reg(REG_ROT_ROW0, {36'd0, 18'h08000});
        send_point(make_point(1, 0, 0, 1, 32'd0, 0, 0));
        send_point(make_point(-1, 0, 0, 1, 32'd0, 0, 0));
        send_point(make_point(3, 0, 0, 1, 32'd0, 0, 1));
        wait_idle();
        write_reg(REG_TRANS_XY, {24'd0, 24'h7FFFFF});
        send_point(make_point(4096, 0, 0, 1, 32'd0, 0, 0));
        send_point(make_point(-32768, 0, 0, 1, 32'd0, 0, 0));
        wait_idle();
        write_reg(REG_TRANS_Z, 24'h800000);
        send_point(make_point(0, 0, -4096, 1, 32'd0, 0, 0));
        send_point(make_point(0, 0, 4096, 1, 32'd0, 0, 1));
        wait_idle();
        // per-frame limit, then the count restarts after the frame end
        write_reg(REG_TRANS_XY, '0);
        write_reg(REG_TRANS_Z, '0);
        write_reg(REG_POINT_LIMIT, 20'd2);
        send_point(make_point(4096, 0, 0, 1, 32'd9, 1, 0));
        send_point(make_point(0, 4096, 0, 1, 32'd9, 1, 0));
        send_point(make_point(0, 0, 4096, 1, 32'd9, 1, 0));
        send_point(make_point(4096, 4096, 0, 1, 32'd9, 1, 1));
        send_point(make_point(-4096, 0, 0, 1, 32'd9, 1, 0));
        wait_idle();
        // min above max: empty window
        write_reg(REG_RANGE_LIMITS, {24'd0, 24'd1});
        send_point(make_point(0, 0, 0, 1, 32'd0, 0, 1));
        wait_idle();
    endtask

    task automatic test_backpressure();
        prc_in_t p;
        wait_idle();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        configure_setup(0);
        write_reg(REG_RANGE_LIMITS, {24'hFFFFFF, 24'h000000});
        wait_idle();
        hold_req++;
        repeat (60) begin
            p = random_point();
            p.coords_valid = 1'b1;
            send_point(p);
        end
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int kinds[8] = '{0, 1, 2, 3, 1, 4, 1, 2};
        int tx_modes[4] = '{0, 68, 0, 14};
        int rx_modes[4] = '{0, 0, 68, 14};
        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            tx_idle_pct  = tx_modes[ph % 4];
            rx_stall_pct = rx_modes[ph % 4];
            configure_setup(kinds[ph]);
            repeat (250) send_point(random_point());
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = '0;
        cfg_wr_data = '0;
        rot_row0_cfg    = ROT_ROW0_RST;
        rot_row1_cfg    = ROT_ROW1_RST;
        rot_row2_cfg    = ROT_ROW2_RST;
        trans_xy_cfg    = '0;
        trans_z_cfg     = '0;
        range_cfg       = RANGE_RST;
        def_var_cfg     = DEF_VAR_RST;
        point_limit_cfg = POINT_LIMIT_RST;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_backpressure();
        test_random_traffic();
        wait_idle();

        if (mismatch_count == 0 && expected_points.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
